// ===== sv/half_size_box_downsampler_macros.svh =====
// assertion macros for the half-size box downsampler checker
// expects clk and rst_n in the scope where a macro is used
`ifndef HALF_SIZE_BOX_DOWNSAMPLER_MACROS_SVH
`define HALF_SIZE_BOX_DOWNSAMPLER_MACROS_SVH

// same-cycle implication
`define HSBD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/hsbd_pkg.sv =====
// shared types and constants of the half-size box downsampler
// no dependencies
package hsbd_pkg;

    localparam int PIX_W        = 8;
    localparam int SUM_W        = 9;
    localparam int DIM_W        = 10;
    localparam int NUM_COLORS   = 3;
    localparam int HEIGHT_LIMIT = 512;
    localparam int WIDTH_RESET  = 320;
    localparam int HEIGHT_RESET = 240;
    localparam int CFG_INDEX_W  = 1;

    typedef logic [PIX_W-1:0]       pix_t;
    typedef logic [SUM_W-1:0]       sum_t;
    typedef logic [DIM_W-1:0]       dim_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_IMAGE_WIDTH  = 1'b0;
    localparam cfg_index_t REG_IMAGE_HEIGHT = 1'b1;

    // averaging operation of one output pixel
    typedef logic [1:0] op_t;
    localparam op_t OP_QUAD  = 2'd0;
    localparam op_t OP_VPAIR = 2'd1;
    localparam op_t OP_HPAIR = 2'd2;
    localparam op_t OP_COPY  = 2'd3;

    typedef struct packed {
        op_t  op;
        logic frame_end;
    } pend_ctrl_t;

endpackage

// ===== sv/hsbd_line_mem.sv =====
// line buffer of upper-row pair sums, one word per output column
// single write port, single read port with registered read data
module hsbd_line_mem #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 27,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/hsbd_lane.sv =====
// one color lane: averages the pixels of a block for one channel
// depends on hsbd_pkg
module hsbd_lane (
    input  hsbd_pkg::op_t  op,
    input  hsbd_pkg::pix_t pix,
    input  hsbd_pkg::pix_t held,
    input  hsbd_pkg::sum_t line_sum,
    output hsbd_pkg::pix_t avg
);
    import hsbd_pkg::*;

    localparam int TW = SUM_W + 1;

    logic [TW-1:0] total;

    always_comb
    begin
        total = '0;
        avg   = '0;
        unique case (op)
            OP_QUAD:
            begin
                total = TW'(line_sum) + TW'(held) + TW'(pix);
                avg   = total[PIX_W+1:2];
            end
            OP_VPAIR:
            begin
                total = TW'(line_sum) + TW'(pix);
                avg   = total[PIX_W:1];
            end
            OP_HPAIR:
            begin
                total = TW'(held) + TW'(pix);
                avg   = total[PIX_W:1];
            end
            OP_COPY:
            begin
                avg = pix;
            end
        endcase
    end

endmodule

// ===== sv/hsbd_out_stage.sv =====
// merge stage: gathers the lane results into the output register
// depends on hsbd_pkg
module hsbd_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pend_valid,
    input  hsbd_pkg::pend_ctrl_t   pend_ctrl,
    input  hsbd_pkg::pix_t         lane_avg [hsbd_pkg::NUM_COLORS],
    output logic                   load,
    output logic                   ds_valid,
    input  logic                   ds_stall,
    output hsbd_pkg::pix_t         red_out,
    output hsbd_pkg::pix_t         green_out,
    output hsbd_pkg::pix_t         blue_out,
    output logic                   frame_end
);
    import hsbd_pkg::*;

    logic valid_reg;
    pix_t color_reg [NUM_COLORS];
    logic frame_end_reg;

    assign load = !valid_reg || !ds_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= pend_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && pend_valid)
        begin
            color_reg     <= lane_avg;
            frame_end_reg <= pend_ctrl.frame_end;
        end
    end

    assign ds_valid  = valid_reg;
    assign red_out   = color_reg[0];
    assign green_out = color_reg[1];
    assign blue_out  = color_reg[2];
    assign frame_end = frame_end_reg;

endmodule

// ===== sv/half_size_box_downsampler.sv =====
// Half-size 2x2 box downsampler: takes RGB pixels of a frame in raster order and
// emits the half-size image in raster order, each 2x2 block giving the truncated
// mean of its pixels per channel (pairs at an odd last column or row, a copy at
// the corner of an odd-by-odd frame). It accepts one pixel per clock while
// pix_stall is low; each result goes through the pending register and then the
// output register, and the line buffer of (MAX_WIDTH+1)/2 words takes at most
// one access per pixel. Writing either dimension register restarts the frame.
// Built on hsbd_pkg, hsbd_line_mem, hsbd_lane and hsbd_out_stage.
module half_size_box_downsampler #(
    parameter int MAX_WIDTH = 512,
    parameter int CHANNELS  = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  hsbd_pkg::cfg_index_t cfg_index,
    input  hsbd_pkg::dim_t       cfg_data,
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  hsbd_pkg::pix_t       red_in,
    input  hsbd_pkg::pix_t       green_in,
    input  hsbd_pkg::pix_t       blue_in,
    output logic                 ds_valid,
    input  logic                 ds_stall,
    output hsbd_pkg::pix_t       red_out,
    output hsbd_pkg::pix_t       green_out,
    output hsbd_pkg::pix_t       blue_out,
    output logic                 frame_end
);
    import hsbd_pkg::*;

    localparam int LANES      = (CHANNELS < NUM_COLORS) ? CHANNELS : NUM_COLORS;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(HEIGHT_LIMIT);
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int LINE_W     = LANES * SUM_W;
    localparam int HELD_W     = LANES * PIX_W;
    localparam int WIDTH_INIT = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam logic [XW-1:0] WLAST_RESET = XW'(WIDTH_INIT - 1);
    localparam logic [YW-1:0] HLAST_RESET = YW'(HEIGHT_RESET - 1);

    logic [XW-1:0] wlast_reg;
    logic [YW-1:0] hlast_reg;
    logic [XW-1:0] wlast_cfg;
    logic [YW-1:0] hlast_cfg;
    logic [XW-1:0] x_reg;
    logic [XW-1:0] x_next;
    logic [YW-1:0] y_reg;
    logic [YW-1:0] y_next;

    pix_t              pix_in [NUM_COLORS];
    logic [HELD_W-1:0] pix_packed;
    logic [HELD_W-1:0] held_reg;
    logic [HELD_W-1:0] pend_pix_reg;
    logic [HELD_W-1:0] pend_held_reg;
    pend_ctrl_t        pend_ctrl_reg;
    logic              pend_valid_reg;

    logic [LINE_W-1:0] line_wdata;
    logic [LINE_W-1:0] line_rdata;
    logic [AW-1:0]     line_addr;
    logic              line_we;
    logic              line_re;
    pix_t              lane_avg [NUM_COLORS];

    logic last_col;
    logic last_row;
    logic odd_x;
    logic odd_y;
    logic row_upper;
    logic row_lower;
    logic emit;
    logic accept;
    logic load;
    op_t  op;

    assign pix_in[0] = red_in;
    assign pix_in[1] = green_in;
    assign pix_in[2] = blue_in;

    // position decode
    assign last_col  = (x_reg == wlast_reg);
    assign last_row  = (y_reg == hlast_reg);
    assign odd_x     = x_reg[0];
    assign odd_y     = y_reg[0];
    assign row_upper = !odd_y && !last_row;
    assign row_lower = odd_y;
    assign emit      = (odd_x || last_col) && !row_upper;

    always_comb
    begin
        priority if (row_lower)
        begin
            op = odd_x ? OP_QUAD : OP_VPAIR;
        end
        else
        begin
            op = odd_x ? OP_HPAIR : OP_COPY;
        end
    end

    assign pix_stall = pend_valid_reg && !load;
    assign accept    = pix_valid && !pix_stall;

    // dimension clamping at write time
    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            wlast_cfg = '0;
        end
        else if (32'(cfg_data) > 32'(MAX_WIDTH))
        begin
            wlast_cfg = XW'(MAX_WIDTH - 1);
        end
        else
        begin
            wlast_cfg = XW'(cfg_data - dim_t'(1));
        end
    end

    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            hlast_cfg = '0;
        end
        else if (32'(cfg_data) > 32'(HEIGHT_LIMIT))
        begin
            hlast_cfg = YW'(HEIGHT_LIMIT - 1);
        end
        else
        begin
            hlast_cfg = YW'(cfg_data - dim_t'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg <= WLAST_RESET;
            hlast_reg <= HLAST_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  wlast_reg <= wlast_cfg;
                REG_IMAGE_HEIGHT: hlast_reg <= hlast_cfg;
            endcase
        end
    end

    // raster position
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        priority if (cfg_we)
        begin
            x_next = '0;
            y_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                x_next = '0;
                y_next = last_row ? '0 : y_reg + YW'(1);
            end
            else
            begin
                x_next = x_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    // line buffer access
    assign line_addr = AW'(x_reg >> 1);
    assign line_we   = accept && row_upper && (odd_x || last_col);
    assign line_re   = accept && row_lower;

    for (genvar k = 0; k < LANES; k++)
    begin : g_pack
        assign pix_packed[k*PIX_W +: PIX_W] = pix_in[k];
        assign line_wdata[k*SUM_W +: SUM_W] = odd_x
            ? SUM_W'(held_reg[k*PIX_W +: PIX_W]) + SUM_W'(pix_in[k])
            : SUM_W'(pix_in[k]);
    end

    hsbd_line_mem #(
        .DEPTH  (LINE_DEPTH),
        .DATA_W (LINE_W),
        .ADDR_W (AW)
    ) u_line_mem (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_addr),
        .wdata (line_wdata),
        .re    (line_re),
        .raddr (line_addr),
        .rdata (line_rdata)
    );

    // held pixel and pending transaction
    always_ff @(posedge clk)
    begin
        if (accept && !odd_x && !last_col)
        begin
            held_reg <= pix_packed;
        end
        if (accept)
        begin
            pend_pix_reg            <= pix_packed;
            pend_held_reg           <= held_reg;
            pend_ctrl_reg.op        <= op;
            pend_ctrl_reg.frame_end <= last_col && last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (!pix_stall)
        begin
            pend_valid_reg <= accept && emit;
        end
    end

    for (genvar k = 0; k < NUM_COLORS; k++)
    begin : g_lane
        if (k < LANES)
        begin : g_used
            hsbd_lane u_lane (
                .op       (pend_ctrl_reg.op),
                .pix      (pend_pix_reg[k*PIX_W +: PIX_W]),
                .held     (pend_held_reg[k*PIX_W +: PIX_W]),
                .line_sum (line_rdata[k*SUM_W +: SUM_W]),
                .avg      (lane_avg[k])
            );
        end
        else
        begin : g_unused
            assign lane_avg[k] = '0;
        end
    end

    hsbd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .pend_valid (pend_valid_reg),
        .pend_ctrl  (pend_ctrl_reg),
        .lane_avg   (lane_avg),
        .load       (load),
        .ds_valid   (ds_valid),
        .ds_stall   (ds_stall),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .frame_end  (frame_end)
    );

endmodule

// ===== sv/hsbd_checker.sv =====
// port-level checker of the half-size box downsampler, bound to the top level
// depends on hsbd_pkg and half_size_box_downsampler_macros.svh
`include "half_size_box_downsampler_macros.svh"

module hsbd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           pix_valid,
    input logic           pix_stall,
    input logic           ds_valid,
    input logic           ds_stall,
    input hsbd_pkg::pix_t red_out,
    input hsbd_pkg::pix_t green_out,
    input hsbd_pkg::pix_t blue_out,
    input logic           frame_end
);

    // a stalled result stays put
    `HSBD_ASSERT_NEXT(a_result_held, ds_valid && ds_stall, ds_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(frame_end), "stalled result transaction changed")

    // input backpressure only comes from a blocked output
    `HSBD_ASSERT_SAME(a_stall_cause, pix_stall, ds_valid && ds_stall, "pixel stall without blocked output")

    // idle, drained cycles that flush the pending and output registers leave nothing to show
    `HSBD_ASSERT_NEXT(a_no_phantom, (!(pix_valid && !pix_stall) && (!ds_valid || !ds_stall)) ##1 (!(pix_valid && !pix_stall) && (!ds_valid || !ds_stall)), !ds_valid, "result transaction without source pixel")

endmodule

bind half_size_box_downsampler hsbd_checker u_hsbd_checker (.*);
